[hw/rtl/i2cbm_pkg.sv]
// types, codes and sequence tables for the bit-level i2c master
// no dependencies; imported by the master, its checker and the testbench
`default_nettype none

package i2cbm_pkg;

  localparam logic [15:0] DELAY_RESET = 16'd10;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_STOP  = 3'd1,
    KIND_WRITE = 3'd2,
    KIND_READ  = 3'd3,
    KIND_SACK  = 3'd4,
    KIND_RACK  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ACT_SCL0 = 3'd0,
    ACT_SCL1 = 3'd1,
    ACT_SDA0 = 3'd2,
    ACT_SDA1 = 3'd3,
    ACT_READ = 3'd4
  } action_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] kind;
    logic [7:0] write_byte;
    logic       ack_bit;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_in;
    logic       cmd_dropped;
  } out_item_t;

  function automatic logic [4:0] seq_len(kind_e k);
    case (k)
      KIND_START: seq_len = 5'd4;
      KIND_STOP:  seq_len = 5'd3;
      KIND_WRITE: seq_len = 5'd24;
      KIND_READ:  seq_len = 5'd25;
      KIND_SACK:  seq_len = 5'd3;
      KIND_RACK:  seq_len = 5'd4;
      default:    seq_len = 5'd0;
    endcase
  endfunction

  // phase walks 0,1,2 through each bit slot of write and read
  function automatic action_e action_of(kind_e k, logic [4:0] idx, logic [1:0] phase,
                                        logic [7:0] tx);
    action_e a;
    a = ACT_SCL0;
    case (k)
      KIND_START: begin
        case (idx[1:0])
          2'd0:    a = ACT_SDA1;
          2'd1:    a = ACT_SCL1;
          2'd2:    a = ACT_SDA0;
          default: a = ACT_SCL0;
        endcase
      end
      KIND_STOP: begin
        if (idx == 5'd0)      a = ACT_SDA0;
        else if (idx == 5'd1) a = ACT_SCL1;
        else                  a = ACT_SDA1;
      end
      KIND_WRITE: begin
        case (phase)
          2'd0:    a = tx[7] ? ACT_SDA1 : ACT_SDA0;
          2'd1:    a = ACT_SCL1;
          default: a = ACT_SCL0;
        endcase
      end
      KIND_READ: begin
        if (idx == 5'd0) begin
          a = ACT_SDA1;
        end else begin
          case (phase)
            2'd0:    a = ACT_SCL1;
            2'd1:    a = ACT_READ;
            default: a = ACT_SCL0;
          endcase
        end
      end
      KIND_SACK: begin
        if (idx == 5'd0)      a = tx[0] ? ACT_SDA1 : ACT_SDA0;
        else if (idx == 5'd1) a = ACT_SCL1;
        else                  a = ACT_SCL0;
      end
      default: begin
        case (idx[1:0])
          2'd0:    a = ACT_SDA1;
          2'd1:    a = ACT_SCL1;
          2'd2:    a = ACT_READ;
          default: a = ACT_SCL0;
        endcase
      end
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/i2c_bit_level_master.sv]
// bit-level i2c master: command sequencer, delay counter and output skid stage
// depends on i2cbm_pkg
`default_nettype none

// One input item is one tick and gives exactly one result item. Every tick
// is processed combinationally by the pin sequencer and the delay counter,
// so a tick can be accepted on every clock; a two-deep output stage (result
// register plus skid register) keeps taking ticks while a result waits, and
// in_stall_o rises only once both are full. A command is taken only while no
// sequence runs; each pin action lasts delay_ticks ticks (0 acts as 1), so a
// command spans 3 to 25 actions times that delay in ticks.
module i2c_bit_level_master
  import i2cbm_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output out_item_t   out_item_o
);

  logic [15:0] delay_q;
  logic [4:0]  idx_q, idx_d;
  logic [15:0] cnt_q, cnt_d;
  kind_e       kind_q, kind_d;
  logic        run_q, run_d;
  logic [7:0]  tx_q, tx_d;
  logic [7:0]  rx_q, rx_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        ack_q, ack_d;
  logic [1:0]  phase_q, phase_d;

  out_item_t   res;
  out_item_t   main_q, skid_q;
  logic        main_valid_q, skid_valid_q;
  logic        accept, take;

  assign accept     = in_valid_i & ~in_stall_o;
  assign take       = main_valid_q & ~out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_comb begin
    logic [15:0] limit;
    logic [15:0] cnt_inc;
    logic [4:0]  idx_inc;
    action_e     act;
    logic        dropped, done;

    idx_d   = idx_q;
    cnt_d   = cnt_q;
    kind_d  = kind_q;
    run_d   = run_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    phase_d = phase_q;
    dropped = 1'b0;
    done    = 1'b0;
    limit   = (delay_q == 16'd0) ? 16'd1 : delay_q;

    if (in_item_i.cmd_valid) begin
      if (run_q) begin
        dropped = 1'b1;
      end else if (in_item_i.kind <= KIND_RACK) begin
        run_d   = 1'b1;
        kind_d  = kind_e'(in_item_i.kind);
        idx_d   = 5'd0;
        cnt_d   = 16'd0;
        phase_d = 2'd0;
        if (kind_d == KIND_WRITE)     tx_d = in_item_i.write_byte;
        else if (kind_d == KIND_SACK) tx_d = {7'd0, in_item_i.ack_bit};
        else if (kind_d == KIND_READ) rx_d = 8'd0;
      end
    end

    act     = action_of(kind_d, idx_d, phase_d, tx_d);
    cnt_inc = cnt_d + 16'd1;
    idx_inc = idx_d + 5'd1;

    if (run_d) begin
      if (cnt_d == 16'd0) begin
        case (act)
          ACT_SCL0: scl_d = 1'b0;
          ACT_SCL1: scl_d = 1'b1;
          ACT_SDA0: sda_d = 1'b0;
          ACT_SDA1: sda_d = 1'b1;
          default: begin
            if (kind_d == KIND_READ) rx_d = {rx_d[6:0], in_item_i.sda_in};
            else                     ack_d = in_item_i.sda_in;
          end
        endcase
      end
      cnt_d = cnt_inc;
      if (cnt_inc >= limit) begin
        cnt_d = 16'd0;
        // the leading release of a read sits outside the bit slots
        if (!(kind_d == KIND_READ && idx_d == 5'd0)) begin
          if (phase_d == 2'd2) begin
            phase_d = 2'd0;
            if (kind_d == KIND_WRITE) tx_d = {tx_d[6:0], 1'b0};
          end else begin
            phase_d = phase_d + 2'd1;
          end
        end
        idx_d = idx_inc;
        if (idx_inc >= seq_len(kind_d)) begin
          run_d = 1'b0;
          idx_d = 5'd0;
          done  = 1'b1;
        end
      end
    end

    res.scl_out     = scl_d;
    res.sda_out     = sda_d;
    res.busy_res    = run_d;
    res.done_res    = done;
    res.read_byte   = rx_d;
    res.ack_in      = ack_d;
    res.cmd_dropped = dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RESET;
    end else if (cfg_we_i) begin
      delay_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 5'd0;
      cnt_q   <= 16'd0;
      kind_q  <= KIND_START;
      run_q   <= 1'b0;
      tx_q    <= 8'd0;
      rx_q    <= 8'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ack_q   <= 1'b1;
      phase_q <= 2'd0;
    end else if (accept) begin
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
      run_q   <= run_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!accept) begin
        main_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!main_valid_q) main_valid_q <= 1'b1;
      else               skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) main_q <= skid_q;
      else if (accept)  main_q <= res;
    end else if (accept) begin
      if (!main_valid_q) main_q <= res;
      else               skid_q <= res;
    end
  end

  assign out_valid_o = main_valid_q;
  assign out_item_o  = main_q;

endmodule

`default_nettype wire

[hw/rtl/i2cbm_checker.sv]
// port-level checks for the bit-level i2c master, bound to the top level
// depends on i2cbm_pkg
`default_nettype none

module i2cbm_checker
  import i2cbm_pkg::*;
(
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input out_item_t  out_item_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // a finished sequence is never still busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res)
    else $error("done with busy set");

  // input stalls only while a result is held at the output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("stall without pending result");

  // every accepted tick leaves a result to show
  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted tick produced no result");

endmodule

bind i2c_bit_level_master i2cbm_checker u_i2cbm_checker (.*);

`default_nettype wire

[tb/tb.sv]
// self-checking testbench for i2c_bit_level_master: a tick-level pin model
// predicts each untyped result item, with random idling on both handshakes
// depends on i2cbm_pkg and the i2c_bit_level_master rtl
module tb;
  import i2cbm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE = 6;
  localparam int PHASE_TICKS = 180;
  localparam int MAX_DELAY_TICKS = 40;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam logic [15:0] DELAY_MAX = 16'hffff;
  localparam logic [15:0] DELAY_CUT = 16'd2;

  localparam out_item_t NO_PINS = '0;
  localparam out_item_t PINS_RESET = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                       done_res: 1'b0, read_byte: 8'h00, ack_in: 1'b1,
                                       cmd_dropped: 1'b0};
  // second tick of a start at unit delay, with a stop arriving
  localparam out_item_t PINS_DROP_SCL_HIGH = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
                                               done_res: 1'b0, read_byte: 8'h00, ack_in: 1'b1,
                                               cmd_dropped: 1'b1};
  // last tick of that start, with a read arriving on the done tick
  localparam out_item_t PINS_DROP_ON_DONE = '{scl_out: 1'b0, sda_out: 1'b0, busy_res: 1'b0,
                                              done_res: 1'b1, read_byte: 8'h00, ack_in: 1'b1,
                                              cmd_dropped: 1'b1};

  typedef struct {
    bit          set_dly;
    logic [15:0] dly;
    in_item_t    item;
    int          reps;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;

  // pin model state
  logic [15:0] m_delay = DELAY_RESET;
  int          m_idx = 0;
  int          m_cnt = 0;
  kind_e       m_kind = KIND_START;
  bit          m_busy = 1'b0;
  logic [7:0]  m_tx = '0;
  logic [7:0]  m_rx = '0;
  logic        m_scl = 1'b1;
  logic        m_sda = 1'b1;
  logic        m_ack = 1'b1;

  out_item_t   pin_expect[$];
  kind_e       cmd_plan[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          stall_left = 0;
  bit          steady = 1'b0;

  i2c_bit_level_master dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #6 clk = ~clk;

  function automatic in_item_t tick(logic v, logic [2:0] k, logic [7:0] b, logic a, logic s);
    in_item_t t;
    t.cmd_valid = v;
    t.kind = k;
    t.write_byte = b;
    t.ack_bit = a;
    t.sda_in = s;
    return t;
  endfunction

  function automatic int action_count(kind_e k);
    case (k)
      KIND_START: return 4;
      KIND_STOP:  return 3;
      KIND_WRITE: return 24;
      KIND_READ:  return 25;
      KIND_SACK:  return 3;
      default:    return 4;
    endcase
  endfunction

  function automatic action_e action_at(kind_e k, int idx, logic [7:0] tx);
    case (k)
      KIND_START: begin
        case (idx)
          0:       return ACT_SDA1;
          1:       return ACT_SCL1;
          2:       return ACT_SDA0;
          default: return ACT_SCL0;
        endcase
      end
      KIND_STOP: begin
        if (idx == 0) return ACT_SDA0;
        return (idx == 1) ? ACT_SCL1 : ACT_SDA1;
      end
      KIND_WRITE: begin
        // data bit, clock high, clock low per bit, msb first
        if (idx % 3 == 0) return tx[7 - idx / 3] ? ACT_SDA1 : ACT_SDA0;
        return (idx % 3 == 1) ? ACT_SCL1 : ACT_SCL0;
      end
      KIND_READ: begin
        if (idx == 0) return ACT_SDA1;
        case ((idx - 1) % 3)
          0:       return ACT_SCL1;
          1:       return ACT_READ;
          default: return ACT_SCL0;
        endcase
      end
      KIND_SACK: begin
        if (idx == 0) return tx[0] ? ACT_SDA1 : ACT_SDA0;
        return (idx == 1) ? ACT_SCL1 : ACT_SCL0;
      end
      default: begin
        case (idx)
          0:       return ACT_SDA1;
          1:       return ACT_SCL1;
          2:       return ACT_READ;
          default: return ACT_SCL0;
        endcase
      end
    endcase
  endfunction

  function automatic out_item_t pins_after_tick(in_item_t it);
    out_item_t r;
    bit dropped;
    bit done;
    int lim;
    dropped = 1'b0;
    done = 1'b0;
    lim = (m_delay == 16'd0) ? 1 : int'(m_delay);
    if (it.cmd_valid) begin
      if (m_busy) begin
        dropped = 1'b1;
      end else if (it.kind <= KIND_RACK) begin
        m_busy = 1'b1;
        m_kind = kind_e'(it.kind);
        m_idx = 0;
        m_cnt = 0;
        if (m_kind == KIND_WRITE) m_tx = it.write_byte;
        else if (m_kind == KIND_SACK) m_tx = {7'd0, it.ack_bit};
        else if (m_kind == KIND_READ) m_rx = '0;
      end
    end
    if (m_busy) begin
      // pin change or sample only on the first tick of an action
      if (m_cnt == 0) begin
        case (action_at(m_kind, m_idx, m_tx))
          ACT_SCL0: m_scl = 1'b0;
          ACT_SCL1: m_scl = 1'b1;
          ACT_SDA0: m_sda = 1'b0;
          ACT_SDA1: m_sda = 1'b1;
          default: begin
            if (m_kind == KIND_READ) m_rx = {m_rx[6:0], it.sda_in};
            else m_ack = it.sda_in;
          end
        endcase
      end
      m_cnt++;
      if (m_cnt >= lim) begin
        m_cnt = 0;
        m_idx++;
        if (m_idx >= action_count(m_kind)) begin
          m_busy = 1'b0;
          m_idx = 0;
          done = 1'b1;
        end
      end
    end
    r.scl_out = m_scl;
    r.sda_out = m_sda;
    r.busy_res = m_busy;
    r.done_res = done;
    r.read_byte = m_rx;
    r.ack_in = m_ack;
    r.cmd_dropped = dropped;
    return r;
  endfunction

  // mostly well-formed transactions, some noise kinds and commands while busy
  function automatic in_item_t random_tick();
    in_item_t t;
    int n;
    t = tick(1'b0, 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    if (!m_busy) begin
      if ($urandom_range(0, 9) < 7) begin
        t.cmd_valid = 1'b1;
        if ($urandom_range(0, 9) != 0) begin
          if (cmd_plan.size() == 0) begin
            cmd_plan.push_back(KIND_START);
            cmd_plan.push_back(KIND_WRITE);
            cmd_plan.push_back(KIND_RACK);
            n = $urandom_range(0, 3);
            repeat (n) begin
              if ($urandom_range(0, 1) == 0) begin
                cmd_plan.push_back(KIND_WRITE);
                cmd_plan.push_back(KIND_RACK);
              end else begin
                cmd_plan.push_back(KIND_READ);
                cmd_plan.push_back(KIND_SACK);
              end
            end
            cmd_plan.push_back(KIND_STOP);
          end
          t.kind = cmd_plan.pop_front();
        end
      end
    end else if ($urandom_range(0, 15) == 0) begin
      t.cmd_valid = 1'b1;
    end
    return t;
  endfunction

  dir_row_t dir_table [27] = '{
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b0), 1, 1'b1, PINS_RESET},
    '{1'b0, 16'd0, tick(1'b1, KIND_SPARE6, 8'h5a, 1'b1, 1'b1), 1, 1'b1, PINS_RESET},
    '{1'b0, 16'd0, tick(1'b1, KIND_SPARE7, 8'ha5, 1'b0, 1'b0), 1, 1'b1, PINS_RESET},
    '{1'b1, 16'd0, tick(1'b1, KIND_START, 8'h00, 1'b0, 1'b0), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b1, KIND_STOP, 8'h00, 1'b0, 1'b1), 1, 1'b1, PINS_DROP_SCL_HIGH},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b0), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b1, KIND_READ, 8'h00, 1'b0, 1'b1), 1, 1'b1, PINS_DROP_ON_DONE},
    '{1'b0, 16'd0, tick(1'b1, KIND_WRITE, 8'hff, 1'b0, 1'b0), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b1), 23, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b1, KIND_WRITE, 8'h00, 1'b1, 1'b1), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b0), 23, 1'b0, NO_PINS},
    '{1'b1, 16'd1, tick(1'b1, KIND_READ, 8'h00, 1'b0, 1'b1), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b1), 24, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b1, KIND_READ, 8'hff, 1'b1, 1'b0), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b0), 24, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b1, KIND_SACK, 8'h00, 1'b0, 1'b1), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b0), 2, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b1, KIND_SACK, 8'h00, 1'b1, 1'b0), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b1), 2, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b1, KIND_RACK, 8'h00, 1'b0, 1'b0), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b0), 3, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b1, KIND_RACK, 8'h00, 1'b1, 1'b1), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b1), 3, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b1, KIND_STOP, 8'h00, 1'b0, 1'b0), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b0), 2, 1'b0, NO_PINS},
    '{1'b1, 16'd2, tick(1'b1, KIND_START, 8'h00, 1'b0, 1'b1), 1, 1'b0, NO_PINS},
    '{1'b0, 16'd0, tick(1'b0, KIND_START, 8'h00, 1'b0, 1'b1), 7, 1'b0, NO_PINS}
  };

  logic [15:0] phase_delay [7] = '{16'd3, 16'd1, 16'd7, 16'd0, DELAY_MAX, 16'd2, 16'd4};

  task automatic push_tick(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t want = '0);
    int gap;
    out_item_t pred;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    pred = pins_after_tick(it);
    pin_expect.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pin_expect.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_delay(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_delay = v;
  endtask

  task automatic set_delay(input logic [15:0] v);
    // let a running sequence finish so the write lands while idle
    while (m_busy) push_tick(tick(1'b0, KIND_START, 8'($urandom), 1'($urandom), 1'($urandom)));
    drain();
    write_delay(v);
  endtask

  task automatic field_check(input string nm, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, nm, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    int hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (pin_expect.size() == 0) begin
        $display("%0t unexpected item: expected none actual %p", $time, out_item);
        mismatches++;
      end else begin
        want = pin_expect.pop_front();
        field_check("scl_out", want.scl_out, out_item.scl_out);
        field_check("sda_out", want.sda_out, out_item.sda_out);
        field_check("busy_res", want.busy_res, out_item.busy_res);
        field_check("done_res", want.done_res, out_item.done_res);
        field_check("read_byte", want.read_byte, out_item.read_byte);
        field_check("ack_in", want.ack_in, out_item.ack_in);
        field_check("cmd_dropped", want.cmd_dropped, out_item.cmd_dropped);
      end
      hold = steady ? 0 : $urandom_range(0, 3);
      stall_left <= hold;
      out_stall <= (hold != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[r]) begin
      if (dir_table[r].set_dly) set_delay(dir_table[r].dly);
      repeat (dir_table[r].reps) push_tick(dir_table[r].item, dir_table[r].typed,
                                           dir_table[r].want);
    end

    foreach (phase_delay[p]) begin
      set_delay(phase_delay[p]);
      if (phase_delay[p] == DELAY_MAX) begin
        // an ack slot at the longest delay, no idling on either side, then a
        // shorter delay mid-action lets the sequence finish
        steady = 1'b1;
        push_tick(tick(1'b1, KIND_SACK, 8'($urandom), 1'($urandom), 1'($urandom)));
        repeat (MAX_DELAY_TICKS) push_tick(tick(1'b0, 3'($urandom), 8'($urandom),
                                                1'($urandom), 1'($urandom)));
        steady = 1'b0;
        drain();
        write_delay(DELAY_CUT);
      end else begin
        for (i = 0; i < PHASE_TICKS; i++) begin
          if (i == PHASE_TICKS / 2) drain();
          push_tick(random_tick());
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/i2cbm_pkg.sv
hw/rtl/i2c_bit_level_master.sv
hw/rtl/i2cbm_checker.sv
tb/tb.sv
